@@ rtl/lzcd_pkg.sv @@
package lzcd_pkg;

  // Sample and geometry widths
  localparam int MAX_WIDTH   = 2048;
  localparam int SAMPLE_BITS = 24;
  localparam int COL_BITS    = $clog2(MAX_WIDTH);
  localparam int FW_BITS     = 12;
  localparam int FH_BITS     = 16;
  localparam int CFG_BITS    = 24;
  localparam int IDX_BITS    = 2;

  typedef logic [SAMPLE_BITS-1:0] sample_t;
  typedef logic [2*SAMPLE_BITS-1:0] line_pair_t;

  // Configuration register indexes
  typedef enum logic [IDX_BITS-1:0] {
    REG_FRAME_WIDTH      = 2'd0,
    REG_FRAME_HEIGHT     = 2'd1,
    REG_STRONG_THRESHOLD = 2'd2
  } reg_index_t;

  localparam logic [FW_BITS-1:0] FRAME_WIDTH_RESET  = FW_BITS'(2048);
  localparam logic [FH_BITS-1:0] FRAME_HEIGHT_RESET = FH_BITS'(2048);
  localparam logic [FW_BITS-1:0] WIDTH_MIN          = FW_BITS'(3);
  localparam logic [FW_BITS-1:0] WIDTH_MAX          = FW_BITS'(MAX_WIDTH);
  localparam logic [FH_BITS-1:0] HEIGHT_MIN         = FH_BITS'(3);

  // True when one value is strictly positive and the other strictly negative
  function automatic logic crosses(input sample_t a, input sample_t b);
    logic a_pos;
    logic a_neg;
    logic b_pos;
    logic b_neg;
    a_neg = a[SAMPLE_BITS-1];
    b_neg = b[SAMPLE_BITS-1];
    a_pos = !a[SAMPLE_BITS-1] && (|a);
    b_pos = !b[SAMPLE_BITS-1] && (|b);
    return (a_pos && b_neg) || (a_neg && b_pos);
  endfunction

endpackage

@@ rtl/log_zero_crossing_detector_core.sv @@
// Zero-crossing detector on a raster stream of LoG samples.
// A sample is held in the sample stage, then its result in the output register.
// One sample per cycle unless stalled; the line store reads and writes once per cycle.
// Reset: counters, window and output valid clear; registers return to their reset values.
// The line store is not cleared and needs no clearing pass.
module log_zero_crossing_detector_core import lzcd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [IDX_BITS-1:0]   cfg_index,
  input  logic [CFG_BITS-1:0]   cfg_data,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  logic [SAMPLE_BITS-1:0] log_value,
  output logic                  out_valid,
  input  logic                  out_stall,
  output logic [SAMPLE_BITS-1:0] edge_value,
  output logic [SAMPLE_BITS-1:0] strong_value,
  output logic                  is_edge,
  output logic                  is_strong,
  output logic                  last_of_frame
);

  // Configuration registers
  logic [FW_BITS-1:0]     frame_width;
  logic [FH_BITS-1:0]     frame_height;
  logic [SAMPLE_BITS-1:0] strong_threshold;

  // Position counters
  logic [COL_BITS-1:0] column_count;
  logic [FH_BITS-1:0]  row_count;

  // Line store: upper row in the high half, middle row in the low half
  line_pair_t line_mem [MAX_WIDTH];
  line_pair_t line_rd;

  // Sample stage
  logic                s_valid;
  sample_t             s_value;
  logic [COL_BITS-1:0] s_col;
  logic                s_produce;
  logic                s_last;

  // Window, index row*3 + col, col 0 oldest
  sample_t window_regs [9];
  sample_t win_next [9];

  logic                in_accept;
  logic                s_advance;
  logic [FW_BITS-1:0]  w_eff;
  logic [FH_BITS-1:0]  h_eff;
  logic                col_wrap;
  logic                row_wrap;
  logic                edge_hit;
  logic                strong_hit;
  sample_t             centre;

  assign in_accept = in_valid && !in_stall;
  assign s_advance = s_valid && (!out_valid || !out_stall);
  assign in_stall  = s_valid && out_valid && out_stall;

  // Clamp geometry
  always_comb begin
    if (frame_width < WIDTH_MIN) begin
      w_eff = WIDTH_MIN;
    end else if (frame_width > WIDTH_MAX) begin
      w_eff = WIDTH_MAX;
    end else begin
      w_eff = frame_width;
    end
    if (frame_height < HEIGHT_MIN) begin
      h_eff = HEIGHT_MIN;
    end else begin
      h_eff = frame_height;
    end
  end

  assign col_wrap = ({1'b0, column_count} + FW_BITS'(1)) >= w_eff;
  assign row_wrap = ({1'b0, row_count} + (FH_BITS+1)'(1)) >= {1'b0, h_eff};

  // Write configuration; unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      frame_width      <= FRAME_WIDTH_RESET;
      frame_height     <= FRAME_HEIGHT_RESET;
      strong_threshold <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FRAME_WIDTH:      frame_width      <= cfg_data[FW_BITS-1:0];
        REG_FRAME_HEIGHT:     frame_height     <= cfg_data[FH_BITS-1:0];
        REG_STRONG_THRESHOLD: strong_threshold <= cfg_data[SAMPLE_BITS-1:0];
        default: ;
      endcase
    end
  end

  // Advance position counters on each input transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      column_count <= '0;
      row_count    <= '0;
    end else if (in_accept) begin
      if (col_wrap) begin
        column_count <= '0;
        if (row_wrap) begin
          row_count <= '0;
        end else begin
          row_count <= row_count + FH_BITS'(1);
        end
      end else begin
        column_count <= column_count + COL_BITS'(1);
      end
    end
  end

  // Sample stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (in_accept) begin
      s_valid <= 1'b1;
    end else if (s_advance) begin
      s_valid <= 1'b0;
    end
  end

  // Capture sample and its position flags
  always_ff @(posedge clk) begin
    if (in_accept) begin
      s_value   <= log_value;
      s_col     <= column_count;
      s_produce <= (row_count >= FH_BITS'(2)) && (column_count >= COL_BITS'(2));
      s_last    <= (row_count == h_eff - FH_BITS'(1))
                && ({1'b0, column_count} == w_eff - FW_BITS'(1));
    end
  end

  // Line store: read on transfer in, write back when the sample stage advances
  always_ff @(posedge clk) begin
    if (in_accept) begin
      line_rd <= line_mem[column_count];
    end
    if (s_advance) begin
      line_mem[s_col] <= {line_rd[SAMPLE_BITS-1:0], s_value};
    end
  end

  // Shift the window by one column
  always_comb begin
    win_next[0] = window_regs[1];
    win_next[1] = window_regs[2];
    win_next[2] = line_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
    win_next[3] = window_regs[4];
    win_next[4] = window_regs[5];
    win_next[5] = line_rd[SAMPLE_BITS-1:0];
    win_next[6] = window_regs[7];
    win_next[7] = window_regs[8];
    win_next[8] = s_value;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 9; i++) begin
        window_regs[i] <= '0;
      end
    end else if (s_advance) begin
      for (int i = 0; i < 9; i++) begin
        window_regs[i] <= win_next[i];
      end
    end
  end

  // Test the four opposite pairs around the centre
  assign centre     = win_next[4];
  assign edge_hit   = crosses(win_next[1], win_next[7])
                   || crosses(win_next[3], win_next[5])
                   || crosses(win_next[2], win_next[6])
                   || crosses(win_next[0], win_next[8]);
  assign strong_hit = edge_hit && ($signed(centre) > $signed(strong_threshold));

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s_advance && s_produce) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  // Load result payload
  always_ff @(posedge clk) begin
    if (s_advance && s_produce) begin
      edge_value    <= edge_hit ? centre : '0;
      strong_value  <= strong_hit ? centre : '0;
      is_edge       <= edge_hit;
      is_strong     <= strong_hit;
      last_of_frame <= s_last;
    end
  end

endmodule

@@ dv/tb.sv @@
module tb;
  import lzcd_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  // Spare register index that the block must ignore
  localparam logic [IDX_BITS-1:0] REG_SPARE = 2'd3;

  localparam sample_t SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam sample_t SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    sample_t edge_value;
    sample_t strong_value;
    logic    is_edge;
    logic    is_strong;
    logic    last_of_frame;
  } crossing_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_we = 1'b0;
  logic [IDX_BITS-1:0]    cfg_index = '0;
  logic [CFG_BITS-1:0]    cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  logic [SAMPLE_BITS-1:0] log_value = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  logic [SAMPLE_BITS-1:0] edge_value;
  logic [SAMPLE_BITS-1:0] strong_value;
  logic                   is_edge;
  logic                   is_strong;
  logic                   last_of_frame;

  // Shadow of the detector: line store, window, counters, registers
  sample_t            upper_row [MAX_WIDTH] = '{default: '0};
  sample_t            middle_row [MAX_WIDTH] = '{default: '0};
  sample_t            win [9] = '{default: '0};
  logic [COL_BITS-1:0] col_q = '0;
  logic [FH_BITS-1:0]  row_q = '0;
  logic [FW_BITS-1:0]  cfg_width = FRAME_WIDTH_RESET;
  logic [FH_BITS-1:0]  cfg_height = FRAME_HEIGHT_RESET;
  sample_t             cfg_thresh = '0;

  sample_t   sample_q [$];
  crossing_t pending_crossings [$];
  int samples_queued = 0;
  int samples_taken = 0;
  int errors = 0;
  int results_seen = 0;
  int edges_seen = 0;
  int strong_seen = 0;
  int frames_seen = 0;
  int cycle_n = 0;
  logic calm;

  log_zero_crossing_detector_core u_dut (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_stall, .log_value,
    .out_valid, .out_stall, .edge_value, .strong_value,
    .is_edge, .is_strong, .last_of_frame
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Stretch of cycles with no idling on either side
  always @(posedge clk) cycle_n <= cycle_n + 1;
  assign calm = (cycle_n >= 800) && (cycle_n < 2000);

  task automatic note_mismatch(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    errors++;
  endtask

  function automatic int eff_width();
    int w;
    w = cfg_width;
    if (w < 3) w = 3;
    if (w > MAX_WIDTH) w = MAX_WIDTH;
    return w;
  endfunction

  function automatic int eff_height();
    int h;
    h = cfg_height;
    if (h < 3) h = 3;
    return h;
  endfunction

  function automatic logic opposite_signs(input sample_t a, input sample_t b);
    return ($signed(a) > 0 && $signed(b) < 0) || ($signed(a) < 0 && $signed(b) > 0);
  endfunction

  // Advance the shadow by one sample and queue the result it causes
  function automatic void predict_crossing(input sample_t s);
    int w;
    int h;
    int c;
    int r;
    sample_t top;
    sample_t mid;
    sample_t ctr;
    logic hit;
    logic strong_hit;
    crossing_t want;
    w = eff_width();
    h = eff_height();
    c = col_q;
    r = row_q;
    top = upper_row[c];
    mid = middle_row[c];
    upper_row[c] = mid;
    middle_row[c] = s;
    win[0] = win[1]; win[1] = win[2]; win[2] = top;
    win[3] = win[4]; win[4] = win[5]; win[5] = mid;
    win[6] = win[7]; win[7] = win[8]; win[8] = s;
    if (r >= 2 && c >= 2) begin
      ctr = win[4];
      hit = opposite_signs(win[1], win[7]) || opposite_signs(win[3], win[5]) ||
            opposite_signs(win[2], win[6]) || opposite_signs(win[0], win[8]);
      strong_hit = hit && ($signed(ctr) > $signed(cfg_thresh));
      want.edge_value = hit ? ctr : '0;
      want.strong_value = strong_hit ? ctr : '0;
      want.is_edge = hit;
      want.is_strong = strong_hit;
      want.last_of_frame = (r == h - 1) && (c == w - 1);
      pending_crossings.push_back(want);
    end
    // Wrap counters at or past their limits
    if (c + 1 >= w) begin
      col_q = '0;
      row_q = (r + 1 >= h) ? '0 : row_q + 1'b1;
    end else begin
      col_q = col_q + 1'b1;
    end
  endfunction

  // Samples still needed to bring both counters back to the frame start
  function automatic int frame_fill_count();
    int c;
    int r;
    int n;
    c = col_q;
    r = row_q;
    n = 0;
    while (c != 0 || r != 0) begin
      if (c + 1 >= eff_width()) begin
        c = 0;
        r = (r + 1 >= eff_height()) ? 0 : ((r + 1) & 16'hFFFF);
      end else begin
        c++;
      end
      n++;
    end
    return n;
  endfunction

  function automatic sample_t pick_sample(input sample_t thr);
    case ($urandom_range(0, 9))
      0: return '0;
      1: return SAMPLE_MAX;
      2: return SAMPLE_MIN;
      3: return $urandom_range(0, 1) ? sample_t'(1) : sample_t'(-1);
      4: return thr;
      5: return $urandom_range(0, 1) ? thr + 1'b1 : thr - 1'b1;
      6, 7: return sample_t'(int'($urandom_range(0, 512)) - 256);
      default: return sample_t'($urandom);
    endcase
  endfunction

  function automatic sample_t pick_threshold();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return SAMPLE_MIN;
      2: return SAMPLE_MAX;
      3: return sample_t'(int'($urandom_range(0, 64)) - 32);
      default: return sample_t'($urandom);
    endcase
  endfunction

  task automatic queue_sample(input sample_t s);
    sample_q.push_back(s);
    samples_queued++;
  endtask

  // Write one register and mirror it into the shadow
  task automatic write_reg(input logic [IDX_BITS-1:0] idx, input logic [CFG_BITS-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      REG_FRAME_WIDTH: cfg_width = data[FW_BITS-1:0];
      REG_FRAME_HEIGHT: cfg_height = data[FH_BITS-1:0];
      REG_STRONG_THRESHOLD: cfg_thresh = data[SAMPLE_BITS-1:0];
      default: ;
    endcase
  endtask

  // Hold until every sample is in and every result is out, then let the pipe empty
  task automatic settle();
    while (samples_taken != samples_queued || pending_crossings.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // Driver: present queued samples, idle at random, hold while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        predict_crossing(log_value);
        samples_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (sample_q.size() != 0 && (calm || $urandom_range(0, 99) >= 20)) begin
          in_valid <= 1'b1;
          log_value <= sample_q.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each result transfer against the oldest expectation
  always @(posedge clk) begin : monitor
    crossing_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (pending_crossings.size() == 0) begin
          note_mismatch("result transfer with no expected result");
        end else begin
          want = pending_crossings.pop_front();
          results_seen++;
          if (want.is_edge) edges_seen++;
          if (want.is_strong) strong_seen++;
          if (want.last_of_frame) frames_seen++;
          if (edge_value !== want.edge_value)
            note_mismatch($sformatf("edge_value got %h want %h", edge_value,
                                    want.edge_value));
          if (strong_value !== want.strong_value)
            note_mismatch($sformatf("strong_value got %h want %h", strong_value,
                                    want.strong_value));
          if (is_edge !== want.is_edge)
            note_mismatch($sformatf("is_edge got %b want %b", is_edge, want.is_edge));
          if (is_strong !== want.is_strong)
            note_mismatch($sformatf("is_strong got %b want %b", is_strong, want.is_strong));
          if (last_of_frame !== want.last_of_frame)
            note_mismatch($sformatf("last_of_frame got %b want %b", last_of_frame,
                                    want.last_of_frame));
        end
      end
      out_stall <= !calm && ($urandom_range(0, 99) < 20);
    end
  end

  initial begin
    sample_t demo_frame [18];
    sample_t thr;
    int w;
    int h;
    int part;
    int rand_start;
    int n;

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    // Directed frame, 6x3: each of the four results crosses on one pair only
    // (vertical, horizontal, anti-diagonal, diagonal); zeros never cross and
    // one centre equals the threshold
    demo_frame = '{
      sample_t'(0), sample_t'(1), sample_t'(0), SAMPLE_MIN, sample_t'(5), sample_t'(0),
      sample_t'(0), sample_t'(1), sample_t'(0), sample_t'(-1), SAMPLE_MAX, sample_t'(0),
      sample_t'(0), sample_t'(-1), sample_t'(-7), sample_t'(0), sample_t'(0), SAMPLE_MAX
    };
    write_reg(REG_FRAME_WIDTH, 24'd6);
    write_reg(REG_FRAME_HEIGHT, 24'd3);
    write_reg(REG_STRONG_THRESHOLD, 24'd0);
    foreach (demo_frame[i]) queue_sample(demo_frame[i]);
    settle();

    // Random frames of small geometry, with out-of-range sizes and spare writes
    rand_start = samples_queued;
    while (samples_queued - rand_start < 450) begin
      case ($urandom_range(0, 7))
        0: w = $urandom_range(0, 2);
        1: w = 3;
        default: w = $urandom_range(3, 12);
      endcase
      case ($urandom_range(0, 7))
        0: h = $urandom_range(0, 2);
        1: h = 3;
        default: h = $urandom_range(3, 8);
      endcase
      thr = pick_threshold();
      // Junk in the unused upper data bits must be dropped
      write_reg(REG_FRAME_WIDTH, {12'($urandom), 12'(w)});
      write_reg(REG_FRAME_HEIGHT, {8'($urandom), 16'(h)});
      write_reg(REG_STRONG_THRESHOLD, thr);
      if ($urandom_range(0, 3) == 0) write_reg(REG_SPARE, 24'($urandom));
      repeat ($urandom_range(1, 3) * eff_width() * eff_height()) queue_sample(pick_sample(thr));
      // Sometimes change the threshold partway through a frame
      if ($urandom_range(0, 2) == 0) begin
        part = $urandom_range(1, eff_width() * eff_height() - 1);
        repeat (part) queue_sample(pick_sample(thr));
        settle();
        thr = pick_threshold();
        write_reg(REG_STRONG_THRESHOLD, thr);
        repeat (frame_fill_count()) queue_sample(pick_sample(thr));
      end
      settle();
    end

    // Tallest frame, then shrink the height mid-frame below the row counter
    thr = pick_threshold();
    write_reg(REG_FRAME_WIDTH, 24'd4);
    write_reg(REG_FRAME_HEIGHT, 24'hFFFF);
    write_reg(REG_STRONG_THRESHOLD, thr);
    repeat (22) queue_sample(pick_sample(thr));
    settle();
    write_reg(REG_FRAME_HEIGHT, 24'd3);
    repeat (frame_fill_count()) queue_sample(pick_sample(thr));
    settle();

    // Shrink the width mid-row below the column counter
    write_reg(REG_FRAME_WIDTH, 24'd8);
    write_reg(REG_FRAME_HEIGHT, 24'd6);
    repeat (30) queue_sample(pick_sample(thr));
    settle();
    write_reg(REG_FRAME_WIDTH, 24'd4);
    repeat (frame_fill_count()) queue_sample(pick_sample(thr));
    settle();

    // Clamped width on a short first row, then a narrow width mid-row
    write_reg(REG_FRAME_WIDTH, 24'hFFF);
    write_reg(REG_FRAME_HEIGHT, 24'd3);
    write_reg(REG_STRONG_THRESHOLD, 24'd0);
    repeat (40) queue_sample(pick_sample('0));
    settle();
    write_reg(REG_FRAME_WIDTH, 24'd5);
    repeat (frame_fill_count()) queue_sample(pick_sample('0));

    // Drain with a bound, then give the pipe time to show any extra result
    n = 0;
    while ((samples_taken != samples_queued || pending_crossings.size() != 0) && n < 20000) begin
      @(posedge clk);
      n++;
    end
    repeat (8) @(posedge clk);
    if (pending_crossings.size() != 0)
      note_mismatch($sformatf("%0d expected results never arrived", pending_crossings.size()));

    $display("Sent %0d LoG samples; checked %0d pixel results, %0d zero crossings, %0d strong",
             samples_taken, results_seen, edges_seen, strong_seen);
    $display("Frames closed: %0d, widths 3 to 12 plus clamped sizes, mid-frame size changes",
             frames_seen);
    if (errors == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

  // Guard against a hung handshake
  initial begin
    #5ms;
    $display("TIMEOUT: run did not complete");
    $display("Mismatches found");
    $finish;
  end

endmodule

@@ log_zero_crossing_detector_core.f @@
rtl/lzcd_pkg.sv
rtl/log_zero_crossing_detector_core.sv
dv/tb.sv
